@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the vertex dedup table RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define TVD_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define TVD_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define TVD_ASSERT(lbl, clk, rst_n, prop, msg)

`define TVD_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

@@ hw/rtl/tvd_pkg.sv @@
// Package with constants, types and helper functions of the vertex dedup table.
package tvd_pkg;

  localparam int SLOT_BITS   = 16;
  localparam int TABLE_SLOTS = 1 << SLOT_BITS;
  localparam int ID_BITS     = 16;
  localparam int COORD_W     = 32;
  localparam int POS_W       = 3 * COORD_W;
  localparam int FACE_W      = 32;
  localparam int VNUM_W      = 16;

  localparam logic [COORD_W-1:0] HASH_K1 = 32'd2654435761;
  localparam logic [COORD_W-1:0] HASH_K2 = 32'd2246822519;
  localparam logic [COORD_W-1:0] HASH_K3 = 32'd3266489917;

  localparam logic MODE_FACE   = 1'b0;
  localparam logic MODE_CORNER = 1'b1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOT_TRI = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

  localparam logic [1:0] CSLOT_NONE = 2'd3;

  typedef struct packed {
    logic               valid;
    logic [POS_W-1:0]   pos;
    logic [ID_BITS-1:0] vid;
  } slot_word_t;

  localparam int WORD_W = $bits(slot_word_t);

  typedef struct packed {
    logic                 done;
    logic [SLOT_BITS-1:0] slot;
  } hash_rsp_t;

  function automatic logic [COORD_W-1:0] canon_zero(input logic [COORD_W-1:0] v);
    return (v[COORD_W-2:0] == '0) ? '0 : v;
  endfunction

  function automatic logic is_nan(input logic [COORD_W-1:0] v);
    return (v[30:23] == 8'hFF) && (v[22:0] != '0);
  endfunction

  function automatic logic [VNUM_W-1:0] vid_to_vnum(input logic [ID_BITS-1:0] v);
    logic [ID_BITS+VNUM_W-1:0] w;
    w = {{VNUM_W{1'b0}}, v};
    return w[VNUM_W-1:0];
  endfunction

endpackage

@@ hw/rtl/tvd_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module tvd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ hw/rtl/tvd_hash.sv @@
// Iterative position hash built around one shared 32 by 32 multiplier.
`include "assert_macros.svh"

module tvd_hash (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic [tvd_pkg::POS_W-1:0] pos,
  output tvd_pkg::hash_rsp_t      rsp
);
  import tvd_pkg::*;

  localparam logic [2:0] H_IDLE = 3'd0;
  localparam logic [2:0] H_MX   = 3'd1;
  localparam logic [2:0] H_MY   = 3'd2;
  localparam logic [2:0] H_MIX1 = 3'd3;
  localparam logic [2:0] H_MIX2 = 3'd4;
  localparam logic [2:0] H_MFIN = 3'd5;
  localparam logic [2:0] H_DONE = 3'd6;

  logic [2:0]           step_r, step_nxt;
  logic [COORD_W-1:0]   h_r, p_r;
  logic [COORD_W-1:0]   mul_a, mul_k, h3, fin;
  logic [2*COORD_W-1:0] prod;
  logic [COORD_W-1:0]   px, py, pz;

  assign px = pos[POS_W-1:2*COORD_W];
  assign py = pos[2*COORD_W-1:COORD_W];
  assign pz = pos[COORD_W-1:0];

  always_comb begin
    mul_a = px;
    mul_k = HASH_K1;
    step_nxt = step_r;
    unique case (step_r)
      H_IDLE: if (start) step_nxt = H_MX;
      H_MX: begin
        step_nxt = H_MY;
      end
      H_MY: begin
        mul_a = py;
        mul_k = HASH_K2;
        step_nxt = H_MIX1;
      end
      H_MIX1: begin
        mul_a = pz;
        mul_k = HASH_K3;
        step_nxt = H_MIX2;
      end
      H_MIX2: step_nxt = H_MFIN;
      H_MFIN: begin
        mul_a = h_r;
        mul_k = HASH_K2;
        step_nxt = H_DONE;
      end
      H_DONE: step_nxt = H_IDLE;
      default: step_nxt = H_IDLE;
    endcase
  end

  assign prod = mul_a * mul_k;
  assign h3   = h_r ^ (p_r + (h_r >> 11));
  assign fin  = p_r ^ (p_r >> 13);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= H_IDLE;
    end else begin
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (step_r)
      H_MX:   h_r <= prod[COORD_W-1:0];
      H_MY:   p_r <= prod[COORD_W-1:0];
      H_MIX1: begin
        h_r <= h_r ^ (p_r + (h_r >> 13));
        p_r <= prod[COORD_W-1:0];
      end
      H_MIX2: h_r <= h3 ^ (h3 >> 15);
      H_MFIN: p_r <= prod[COORD_W-1:0];
      default: begin
      end
    endcase
  end

  assign rsp.done = (step_r == H_DONE);
  assign rsp.slot = fin[SLOT_BITS-1:0];

  `TVD_ASSERT(a_done_single, clk, rst_n, rsp.done |=> !rsp.done, "hash done held")

endmodule

@@ hw/rtl/triangle_vertex_dedup_table_core.sv @@
// Top level of the triangle vertex dedup table: control, probing and result register.
//
// Each request is a face start or a corner position; each yields one result. After reset
// the table memory is cleared one slot per cycle, so no request is taken until all 65536
// slots (TABLE_SLOTS) are cleared. A face start waits in S_FACE until the result register
// is free. A corner first runs the hash, whose single multiplier is used four times, and
// then the one-port-read table memory is compared one slot per cycle along the linear
// probe chain until a match, an empty slot or a full wrap. The result register lets a
// finished result wait while the next request is taken.
`include "assert_macros.svh"

module triangle_vertex_dedup_table_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_mode,
  input  logic [tvd_pkg::COORD_W-1:0] in_coord_x,
  input  logic [tvd_pkg::COORD_W-1:0] in_coord_y,
  input  logic [tvd_pkg::COORD_W-1:0] in_coord_z,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_item_kind,
  output logic [tvd_pkg::FACE_W-1:0]  out_face_number,
  output logic [1:0]                  out_corner_slot,
  output logic [tvd_pkg::VNUM_W-1:0]  out_vertex_number,
  output logic                        out_first_seen,
  output logic [1:0]                  out_status
);
  import tvd_pkg::*;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_FACE  = 3'd2;
  localparam logic [2:0] S_HASH  = 3'd3;
  localparam logic [2:0] S_PROBE = 3'd4;

  logic [2:0]           state_r, state_nxt;
  logic [SLOT_BITS-1:0] clr_addr_r;
  logic [SLOT_BITS-1:0] slot_r;
  logic [SLOT_BITS-1:0] probe_cnt_r;
  logic [ID_BITS:0]     next_vid_r;
  logic [FACE_W-1:0]    face_cnt_r;
  logic [1:0]           corners_r;
  logic [POS_W-1:0]     pos_r;
  logic                 nan_r;
  logic [FACE_W-1:0]    fnum_r;
  logic [1:0]           cslot_r;
  logic [1:0]           stat_r;

  logic                 out_valid_r;
  logic                 out_item_kind_r;
  logic [FACE_W-1:0]    out_face_number_r;
  logic [1:0]           out_corner_slot_r;
  logic [VNUM_W-1:0]    out_vertex_number_r;
  logic                 out_first_seen_r;
  logic [1:0]           out_status_r;

  hash_rsp_t            hrsp;
  logic                 hash_start;
  logic                 accept;
  logic                 we;
  logic [SLOT_BITS-1:0] waddr, raddr;
  slot_word_t           wword, rword;
  logic [WORD_W-1:0]    rdata;
  logic                 hit, empty, last, room, stop, decide, advance;
  logic                 out_free, commit, insert, face_load;

  assign in_ready   = (state_r == S_IDLE);
  assign accept     = in_valid && in_ready;
  assign hash_start = accept && (in_mode == MODE_CORNER);

  tvd_hash u_hash (
    .clk  (clk),
    .rst_n(rst_n),
    .start(hash_start),
    .pos  (pos_r),
    .rsp  (hrsp)
  );

  tvd_ram #(
    .WIDTH(WORD_W),
    .DEPTH(TABLE_SLOTS)
  ) u_table (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wword),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign rword   = slot_word_t'(rdata);
  assign hit     = rword.valid && (rword.pos == pos_r) && !nan_r;
  assign empty   = !rword.valid;
  assign last    = &probe_cnt_r;
  assign room    = !next_vid_r[ID_BITS];
  assign stop    = hit || empty || last;
  assign decide  = (state_r == S_PROBE) && stop;
  assign advance = (state_r == S_PROBE) && !stop;

  assign out_free  = !out_valid_r || out_ready;
  assign commit    = decide && out_free;
  assign insert    = commit && !hit && empty && room;
  assign face_load = (state_r == S_FACE) && out_free;

  always_comb begin
    if (state_r == S_HASH) begin
      raddr = hrsp.slot;
    end else if (advance) begin
      raddr = slot_r + 1'b1;
    end else begin
      raddr = slot_r;
    end
  end

  always_comb begin
    we = (state_r == S_CLEAR) || insert;
    if (state_r == S_CLEAR) begin
      waddr = clr_addr_r;
      wword = '0;
    end else begin
      waddr       = slot_r;
      wword.valid = 1'b1;
      wword.pos   = pos_r;
      wword.vid   = next_vid_r[ID_BITS-1:0];
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: if (&clr_addr_r) state_nxt = S_IDLE;
      S_IDLE: begin
        if (accept) begin
          state_nxt = (in_mode == MODE_FACE) ? S_FACE : S_HASH;
        end
      end
      S_FACE:  if (out_free) state_nxt = S_IDLE;
      S_HASH:  if (hrsp.done) state_nxt = S_PROBE;
      S_PROBE: if (commit) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_addr_r  <= '0;
      probe_cnt_r <= '0;
      next_vid_r  <= '0;
      face_cnt_r  <= '0;
      corners_r   <= CSLOT_NONE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) begin
        clr_addr_r <= clr_addr_r + 1'b1;
      end
      if (hrsp.done) begin
        probe_cnt_r <= '0;
      end else if (advance) begin
        probe_cnt_r <= probe_cnt_r + 1'b1;
      end
      if (insert) begin
        next_vid_r <= next_vid_r + 1'b1;
      end
      if (accept) begin
        if (in_mode == MODE_FACE) begin
          face_cnt_r <= face_cnt_r + 1'b1;
          corners_r  <= '0;
        end else if (corners_r != CSLOT_NONE) begin
          corners_r <= corners_r + 1'b1;
        end
      end
      if (commit || face_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pos_r <= {canon_zero(in_coord_x), canon_zero(in_coord_y), canon_zero(in_coord_z)};
      nan_r <= is_nan(in_coord_x) || is_nan(in_coord_y) || is_nan(in_coord_z);
      if (in_mode == MODE_FACE) begin
        fnum_r <= face_cnt_r;
      end else begin
        fnum_r <= face_cnt_r - 1'b1;
      end
      cslot_r <= corners_r;
      stat_r  <= (corners_r == CSLOT_NONE) ? ST_NOT_TRI : ST_OK;
    end
    if (hrsp.done) begin
      slot_r <= hrsp.slot;
    end else if (advance) begin
      slot_r <= slot_r + 1'b1;
    end
    if (face_load) begin
      out_item_kind_r     <= MODE_FACE;
      out_face_number_r   <= fnum_r;
      out_corner_slot_r   <= '0;
      out_vertex_number_r <= '0;
      out_first_seen_r    <= 1'b0;
      out_status_r        <= ST_OK;
    end else if (commit) begin
      out_item_kind_r   <= MODE_CORNER;
      out_face_number_r <= fnum_r;
      out_corner_slot_r <= cslot_r;
      out_first_seen_r  <= insert;
      if (hit) begin
        out_vertex_number_r <= vid_to_vnum(rword.vid);
        out_status_r        <= stat_r;
      end else if (insert) begin
        out_vertex_number_r <= vid_to_vnum(next_vid_r[ID_BITS-1:0]);
        out_status_r        <= stat_r;
      end else begin
        out_vertex_number_r <= '0;
        out_status_r        <= ST_FULL;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_item_kind     = out_item_kind_r;
  assign out_face_number   = out_face_number_r;
  assign out_corner_slot   = out_corner_slot_r;
  assign out_vertex_number = out_vertex_number_r;
  assign out_first_seen    = out_first_seen_r;
  assign out_status        = out_status_r;

  `TVD_ASSERT(a_write_when_owned, clk, rst_n, we |-> (state_r == S_CLEAR || state_r == S_PROBE), "table write outside clear or probe")
  `TVD_ASSERT(a_hash_in_hash, clk, rst_n, hrsp.done |-> (state_r == S_HASH), "hash done outside hash state")
  `TVD_ASSERT_NEVER(a_vid_bound, clk, rst_n, next_vid_r[ID_BITS] && (next_vid_r[ID_BITS-1:0] != '0), "vertex count past limit")
  `TVD_ASSERT(a_insert_result, clk, rst_n, insert |=> (out_valid_r && out_first_seen_r), "insert without first seen result")

endmodule
